// File: rtl/ffpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit page run allocator.
// Depends on nothing; every other file of the block uses it.
package ffpa_pkg;

   // Field widths of the request, response and register words.
   localparam int unsigned ADDR_W        = 32;
   localparam int unsigned COUNT_W       = 11;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned PAGE_SHIFT    = 12;
   localparam int unsigned PAGE_NUM_W    = ADDR_W - PAGE_SHIFT;
   localparam int unsigned MAX_PAGES_DEF = 1024;

   // Register reset values.
   localparam logic [ADDR_W-1:0]  REGION_BASE_RST    = '0;
   localparam logic [COUNT_W-1:0] TOTAL_PAGES_RST    = COUNT_W'(1024);
   localparam logic [COUNT_W-1:0] RESERVED_PAGES_RST = '0;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE    = 2'd0,
      CSR_TOTAL_PAGES    = 2'd1,
      CSR_RESERVED_PAGES = 2'd2
   } csr_index_type;

   // One entry of the page table: busy bit, run start mark and run length.
   typedef struct packed {
      logic               busy;
      logic               mark;
      logic [COUNT_W-1:0] len;
   } page_word_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SCAN,
      RD_FREE
   } rd_kind_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ZERO,
      WR_MARK
   } wr_kind_type;

   typedef enum logic [1:0] {
      WALK_HOLD,
      WALK_ALLOC,
      WALK_FREE
   } walk_kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_SCAN,
      S_ALLOC_MARK,
      S_FREE_CHECK,
      S_FREE_CLEAR,
      S_RESPOND
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          req_ready;
      logic          scan_init;
      rd_kind_type   rd_kind;
      wr_kind_type   wr_kind;
      walk_kind_type walk_kind;
      logic          code_we;
      status_type    code;
      logic          rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_accept;
      logic is_free;
      logic count_zero;
      logic free_ok;
      logic scan_hit;
      logic scan_miss;
      logic run_marked;
      logic walk_last;
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: rtl/ffpa_if.sv
`timescale 1ns / 1ps
// Handshake channels of the allocator: request, response and register write.
// Depends on ffpa_pkg for the field widths.

interface ffpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ffpa_pkg::COUNT_W-1:0]  page_count;
   logic [ffpa_pkg::ADDR_W-1:0]   address;

   modport source (output valid, action, page_count, address, input ready);
   modport sink   (input valid, action, page_count, address, output ready);
endinterface

interface ffpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffpa_pkg::STATUS_W-1:0] status;
   logic [ffpa_pkg::ADDR_W-1:0]   run_address;

   modport source (output valid, status, run_address, input ready);
   modport sink   (input valid, status, run_address, output ready);
endinterface

interface ffpa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ffpa_pkg::CSR_IDX_W-1:0]  index;
   logic [ffpa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/first_fit_page_run_allocator.sv
`timescale 1ns / 1ps
// First-fit page run allocator. After reset the page table is cleared one
// entry per cycle, during which no request word is taken (register writes
// are taken at any time). An allocate word scans the pages from page 0 up to
// the end of the first free run that fits (at most the managed page count),
// then marks each page of the run busy; a zero count fails without a scan.
// A free word reads the entry at its address, then clears each page of the
// run. The page table is read or written at most once per cycle.
// One word is in work at a time; its response sits in an output register, so
// the next request is taken while the response waits.
// Depends on ffpa_pkg, ffpa_if, ffpa_ctrl and ffpa_dpath.
module first_fit_page_run_allocator #(
   parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffpa_req_if.sink   req_ch,
   ffpa_rsp_if.source rsp_ch,
   ffpa_csr_if.sink   csr_ch
);
   import ffpa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   ffpa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Storage and arithmetic.
   ffpa_dpath #(
      .MAX_PAGES (MAX_PAGES)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// File: rtl/ffpa_ctrl.sv
`timescale 1ns / 1ps
// Controller of the allocator: sequences table clearing, scans and run walks.
// Depends on ffpa_pkg; drives the datapath only through command and status.
module ffpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ffpa_pkg::dp_status_type status,
   output ffpa_pkg::dp_cmd_type    cmd
);
   import ffpa_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (status.req_accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (status.is_free) begin
               state_in = status.free_ok ? S_FREE_CHECK : S_RESPOND;
            end else begin
               state_in = status.count_zero ? S_RESPOND : S_ALLOC_SCAN;
            end
         end
         S_ALLOC_SCAN: begin
            if (status.scan_hit) begin
               state_in = S_ALLOC_MARK;
            end else if (status.scan_miss) begin
               state_in = S_RESPOND;
            end
         end
         S_ALLOC_MARK: begin
            if (status.walk_last) state_in = S_RESPOND;
         end
         S_FREE_CHECK: begin
            state_in = status.run_marked ? S_FREE_CLEAR : S_RESPOND;
         end
         S_FREE_CLEAR: begin
            if (status.walk_last) state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.rd_kind   = RD_NONE;
      cmd.wr_kind   = WR_NONE;
      cmd.walk_kind = WALK_HOLD;
      cmd.code      = ST_DONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_kind = WR_ZERO;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         S_DISPATCH: begin
            if (status.is_free) begin
               if (status.free_ok) begin
                  cmd.rd_kind = RD_FREE;
               end else begin
                  cmd.code_we = 1'b1;
                  cmd.code    = ST_NOT_FOUND;
               end
            end else if (status.count_zero) begin
               cmd.code_we = 1'b1;
               cmd.code    = ST_NO_SPACE;
            end else begin
               cmd.scan_init = 1'b1;
            end
         end
         S_ALLOC_SCAN: begin
            cmd.rd_kind = RD_SCAN;
            if (status.scan_hit) begin
               cmd.walk_kind = WALK_ALLOC;
            end else if (status.scan_miss) begin
               cmd.code_we = 1'b1;
               cmd.code    = ST_NO_SPACE;
            end
         end
         S_ALLOC_MARK: begin
            cmd.wr_kind = WR_MARK;
            if (status.walk_last) begin
               cmd.code_we = 1'b1;
               cmd.code    = ST_DONE;
            end
         end
         S_FREE_CHECK: begin
            if (status.run_marked) begin
               cmd.walk_kind = WALK_FREE;
            end else begin
               cmd.code_we = 1'b1;
               cmd.code    = ST_NOT_FOUND;
            end
         end
         S_FREE_CLEAR: begin
            cmd.wr_kind = WR_ZERO;
            if (status.walk_last) begin
               cmd.code_we = 1'b1;
               cmd.code    = ST_DONE;
            end
         end
         S_RESPOND: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.wr_kind = WR_NONE;
         end
      endcase
   end

endmodule

// File: rtl/ffpa_dpath.sv
`timescale 1ns / 1ps
// Datapath of the allocator: registers, page table memory, scan and walk
// counters, and the response register. Depends on ffpa_pkg and ffpa_if.
module ffpa_dpath #(
   parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   ffpa_req_if.sink                req_ch,
   ffpa_rsp_if.source              rsp_ch,
   ffpa_csr_if.sink                csr_ch,
   input  ffpa_pkg::dp_cmd_type    cmd,
   output ffpa_pkg::dp_status_type status
);
   import ffpa_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_PAGES);
   localparam int unsigned NUM_W = $clog2(MAX_PAGES + 1);
   localparam int unsigned LIM_W = (NUM_W > COUNT_W) ? NUM_W : COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);
   localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_PAGES);

   // Configuration registers.
   logic [ADDR_W-1:0]  region_base_ff;
   logic [COUNT_W-1:0] total_pages_ff;
   logic [COUNT_W-1:0] reserved_pages_ff;

   // Latched request word.
   action_type         action_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [ADDR_W-1:0]  address_ff;

   // Page table.
   page_word_type      page_mem [MAX_PAGES];
   page_word_type      rdata_ff;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic               mem_we;
   page_word_type      mem_wdata;

   // Scan state.
   logic [NUM_W-1:0]   issue_ff,  issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [COUNT_W-1:0] run_ff,    run_in;
   logic [IDX_W-1:0]   start_ff,  start_in;

   // Run walk state.
   logic [IDX_W-1:0]   walk_ff,   walk_in;
   logic [COUNT_W-1:0] rem_ff,    rem_in;

   // Result.
   status_type         code_ff;
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;

   logic [LIM_W-1:0]   limit;
   logic [LIM_W-1:0]   res_lim;
   logic [ADDR_W-1:0]  offset;
   logic [PAGE_NUM_W-1:0] page_num;
   logic [IDX_W-1:0]   free_idx;
   logic               free_ok;
   logic               taken;
   logic [COUNT_W-1:0] run_next;
   logic               scan_hit;
   logic               can_issue;
   logic [IDX_W-1:0]   hit_start;
   logic               req_accept;
   logic               rsp_free;
   logic [ADDR_W-1:0]  run_addr;

   // Register writes; the port never stalls.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff    <= REGION_BASE_RST;
         total_pages_ff    <= TOTAL_PAGES_RST;
         reserved_pages_ff <= RESERVED_PAGES_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_REGION_BASE:    region_base_ff    <= csr_ch.data;
            CSR_TOTAL_PAGES:    total_pages_ff    <= csr_ch.data[COUNT_W-1:0];
            CSR_RESERVED_PAGES: reserved_pages_ff <= csr_ch.data[COUNT_W-1:0];
            default:            region_base_ff    <= region_base_ff;
         endcase
      end
   end

   // Page counts saturate at the table depth.
   assign limit   = (LIM_W'(total_pages_ff) > MAX_LIM) ? MAX_LIM : LIM_W'(total_pages_ff);
   assign res_lim = (LIM_W'(reserved_pages_ff) > MAX_LIM) ?
                    MAX_LIM : LIM_W'(reserved_pages_ff);

   // Request capture.
   assign req_accept   = req_ch.valid && cmd.req_ready;
   assign req_ch.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff  <= action_type'(req_ch.action);
         count_ff   <= req_ch.page_count;
         address_ff <= req_ch.address;
      end
   end

   // Free address decode: page aligned offset that lies inside the managed pages.
   assign offset   = address_ff - region_base_ff;
   assign page_num = offset[ADDR_W-1:PAGE_SHIFT];
   assign free_idx = page_num[IDX_W-1:0];
   assign free_ok  = (offset[PAGE_SHIFT-1:0] == '0) &&
                     (page_num < PAGE_NUM_W'(limit));

   // Scan evaluation of the page whose entry has just been read.
   assign taken     = (LIM_W'(rd_idx_ff) < res_lim) || rdata_ff.busy;
   assign run_next  = run_ff + COUNT_W'(1);
   assign scan_hit  = rd_valid_ff && !taken && (run_next == count_ff);
   assign can_issue = LIM_W'(issue_ff) < limit;
   assign hit_start = (run_ff == '0) ? rd_idx_ff : start_ff;

   always_comb begin
      issue_in    = issue_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in   = rd_idx_ff;
      run_in      = run_ff;
      start_in    = start_ff;
      if (cmd.scan_init) begin
         issue_in    = '0;
         rd_valid_in = 1'b0;
         run_in      = '0;
      end else if (cmd.rd_kind == RD_SCAN) begin
         rd_valid_in = can_issue && !scan_hit;
         rd_idx_in   = issue_ff[IDX_W-1:0];
         if (can_issue && !scan_hit) begin
            issue_in = issue_ff + NUM_W'(1);
         end
         if (rd_valid_ff) begin
            run_in = taken ? '0 : run_next;
            if (!taken && run_ff == '0) begin
               start_in = rd_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      run_ff    <= run_in;
      start_ff  <= start_in;
   end

   // Run walk: one page written per cycle, also used by the clearing pass.
   always_comb begin
      walk_in = walk_ff;
      rem_in  = rem_ff;
      case (cmd.walk_kind)
         WALK_ALLOC: begin
            walk_in = hit_start;
            rem_in  = count_ff;
         end
         WALK_FREE: begin
            walk_in = free_idx;
            rem_in  = rdata_ff.len;
         end
         default: begin
            if (cmd.wr_kind != WR_NONE) begin
               walk_in = walk_ff + IDX_W'(1);
               rem_in  = rem_ff - COUNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
      end else begin
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   // Page table ports.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = free_idx;
      case (cmd.rd_kind)
         RD_SCAN: begin
            mem_re    = can_issue && !scan_hit;
            mem_raddr = issue_ff[IDX_W-1:0];
         end
         RD_FREE: begin
            mem_re    = 1'b1;
            mem_raddr = free_idx;
         end
         default: mem_re = 1'b0;
      endcase
   end

   always_comb begin
      mem_we    = cmd.wr_kind != WR_NONE;
      mem_wdata = '0;
      if (cmd.wr_kind == WR_MARK) begin
         mem_wdata.busy = 1'b1;
         mem_wdata.mark = walk_ff == start_ff;
         mem_wdata.len  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[walk_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= page_mem[mem_raddr];
      end
   end

   // Result code.
   always_ff @(posedge clock) begin
      if (cmd.code_we) begin
         code_ff <= cmd.code;
      end
   end

   // Response register; a waiting word is replaced once it has been taken.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign run_addr = ((action_ff == ACT_ALLOC) && (code_ff == ST_DONE)) ?
                     region_base_ff + (ADDR_W'(start_ff) << PAGE_SHIFT) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= code_ff;
         rsp_addr_ff   <= run_addr;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.run_address = rsp_addr_ff;

   // Status to the controller.
   always_comb begin
      status            = '0;
      status.req_accept = req_accept;
      status.is_free    = action_ff == ACT_FREE;
      status.count_zero = count_ff == '0;
      status.free_ok    = free_ok;
      status.scan_hit   = scan_hit;
      status.scan_miss  = !rd_valid_ff && !can_issue;
      status.run_marked = rdata_ff.mark;
      status.walk_last  = (rem_ff == COUNT_W'(1)) || (walk_ff == LAST_IDX);
      status.clear_last = walk_ff == LAST_IDX;
      status.rsp_free   = rsp_free;
   end

endmodule

// File: tb/ffpa_page_table_checker.sv
`timescale 1ns / 1ps
// Response checker for the first-fit page run allocator: keeps its own page map,
// predicts the response to every accepted request word and compares in order.
// Depends on ffpa_pkg and the channel interfaces of ffpa_if.
module ffpa_page_table_checker #(
   parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        end_of_run,
   ffpa_req_if         req_ch,
   ffpa_rsp_if         rsp_ch,
   ffpa_csr_if         csr_ch,
   output int unsigned mismatches
);
   import ffpa_pkg::*;

   localparam int unsigned PRINT_CAP = 100;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] run_address;
   } response_word_type;

   // Register copies and the predicted page map.
   logic [ADDR_W-1:0]  base_q;
   logic [COUNT_W-1:0] total_q;
   logic [COUNT_W-1:0] reserved_q;
   logic               busy_q [MAX_PAGES];
   logic               mark_q [MAX_PAGES];
   logic [COUNT_W-1:0] len_q  [MAX_PAGES];

   response_word_type pending_responses [$];
   bit                leftovers_reported;

   // Page counts above the map size behave as the map size.
   function automatic int unsigned clamp_pages(input logic [COUNT_W-1:0] v);
      return (v > MAX_PAGES) ? MAX_PAGES : int'(v);
   endfunction

   // Prints one line for the first PRINT_CAP mismatches and counts them all.
   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   // Works out the response to one request word and updates the page map.
   task automatic predict_page_request(input logic action,
                                       input logic [COUNT_W-1:0] count,
                                       input logic [ADDR_W-1:0] addr,
                                       output response_word_type rsp);
      int unsigned       limit;
      int unsigned       resv;
      int unsigned       run;
      int unsigned       start;
      int unsigned       i;
      int unsigned       j;
      int unsigned       page;
      int unsigned       len;
      logic [ADDR_W-1:0] offset;
      limit = clamp_pages(total_q);
      resv  = clamp_pages(reserved_q);
      rsp.status      = ST_NO_SPACE;
      rsp.run_address = '0;
      if (action == ACT_ALLOC) begin
         // First fit: scan upwards from page 0 for count free pages in a row.
         if (count != 0) begin
            run   = 0;
            start = 0;
            i     = 0;
            while (i < limit && run != count) begin
               if (i < resv || busy_q[i]) begin
                  run = 0;
               end else begin
                  if (run == 0) start = i;
                  run++;
               end
               i++;
            end
            if (run == count) begin
               for (j = 0; j < count; j++) busy_q[start + j] = 1'b1;
               mark_q[start]   = 1'b1;
               len_q[start]    = count;
               rsp.status      = ST_DONE;
               rsp.run_address = base_q + ADDR_W'(start << PAGE_SHIFT);
            end
         end
      end else begin
         // A free only matches an aligned offset that names a marked run start.
         rsp.status = ST_NOT_FOUND;
         offset     = addr - base_q;
         page       = offset >> PAGE_SHIFT;
         if (offset[PAGE_SHIFT-1:0] == '0 && page < limit && mark_q[page]) begin
            len = len_q[page];
            for (j = 0; j < len && page + j < MAX_PAGES; j++) busy_q[page + j] = 1'b0;
            mark_q[page] = 1'b0;
            rsp.status   = ST_DONE;
         end
      end
   endtask

   always @(posedge clock) begin
      response_word_type want;
      if (reset) begin
         base_q     = REGION_BASE_RST;
         total_q    = TOTAL_PAGES_RST;
         reserved_q = RESERVED_PAGES_RST;
         for (int n = 0; n < MAX_PAGES; n++) begin
            busy_q[n] = 1'b0;
            mark_q[n] = 1'b0;
            len_q[n]  = '0;
         end
         pending_responses.delete();
         leftovers_reported = 1'b0;
         mismatches         = 0;
      end else begin
         // Compare each response word with the oldest prediction.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch($sformatf(
                  "response word with nothing outstanding: status %0d address %h",
                  rsp_ch.status, rsp_ch.run_address));
            end else begin
               want = pending_responses.pop_front();
               if (rsp_ch.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_ch.status, want.status));
               end
               if (rsp_ch.run_address !== want.run_address) begin
                  report_mismatch($sformatf("run_address %h, predicted %h",
                                            rsp_ch.run_address, want.run_address));
               end
            end
         end

         // Register writes; an index with no register behind it is ignored.
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_REGION_BASE:    base_q     = csr_ch.data;
               CSR_TOTAL_PAGES:    total_q    = csr_ch.data[COUNT_W-1:0];
               CSR_RESERVED_PAGES: reserved_q = csr_ch.data[COUNT_W-1:0];
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            predict_page_request(req_ch.action, req_ch.page_count, req_ch.address, want);
            pending_responses.push_back(want);
         end

         // Any prediction still waiting at the end never got its response.
         if (end_of_run && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            foreach (pending_responses[n]) begin
               report_mismatch($sformatf("no response for prediction: status %0d address %h",
                                         pending_responses[n].status,
                                         pending_responses[n].run_address));
            end
            pending_responses.delete();
         end
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on ffpa_pkg, ffpa_if, the
// block and ffpa_page_table_checker.
module tb_top;
   import ffpa_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 10_000_000;
   localparam int unsigned RANDOM_WORDS = 530;
   localparam int unsigned DRAIN_CYCLES = 2100;
   localparam int unsigned STALE_DEPTH  = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic clock;
   logic reset;
   logic end_of_run;

   ffpa_req_if req_ch ();
   ffpa_rsp_if rsp_ch ();
   ffpa_csr_if csr_ch ();

   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned words_sent;
   int unsigned words_returned;
   int unsigned runs_granted;
   int unsigned runs_released;
   int unsigned settings_used;

   // Set for a whole setting to run both sides without idling.
   bit quiet;

   // Stimulus view of the block: current base and page count, runs held.
   logic [ADDR_W-1:0] cur_base;
   int unsigned       cur_total;
   action_type        sent_actions [$];
   int unsigned       live_pages   [$];
   int unsigned       stale_pages  [$];

   first_fit_page_run_allocator #(
      .MAX_PAGES (MAX_PAGES_DEF)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ffpa_page_table_checker #(
      .MAX_PAGES (MAX_PAGES_DEF)
   ) page_checker (
      .clock      (clock),
      .reset      (reset),
      .end_of_run (end_of_run),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .mismatches (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles without finishing", cycle_count);
      $display("tb_top NOT OK");
      $finish;
   end

   // Response side: random stall before each word, and a note of what it brings.
   initial begin
      int unsigned stall;
      action_type  act;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         words_returned++;
         act = (sent_actions.size() != 0) ? sent_actions.pop_front() : ACT_FREE;
         if (rsp_ch.status == ST_DONE) begin
            if (act == ACT_ALLOC) begin
               live_pages.push_back((rsp_ch.run_address - cur_base) >> PAGE_SHIFT);
               runs_granted++;
            end else begin
               runs_released++;
            end
         end
      end
   end

   // Offers one request word after a random gap and waits until it is taken.
   task automatic send_word(input action_type act, input int unsigned count,
                            input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.page_count <= COUNT_W'(count);
      req_ch.address    <= addr;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sent_actions.push_back(act);
      words_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Every request gives a response, so the block is idle once all are back.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      while (words_returned != words_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [ADDR_W-1:0] base, input int unsigned total,
                            input int unsigned reserved);
      wait_until_idle();
      write_register(CSR_REGION_BASE, base);
      write_register(CSR_TOTAL_PAGES, CSR_DATA_W'(total));
      write_register(CSR_RESERVED_PAGES, CSR_DATA_W'(reserved));
      cur_base  = base;
      cur_total = (total > MAX_PAGES_DEF) ? MAX_PAGES_DEF : total;
      settings_used++;
   endtask

   initial begin
      int unsigned       k;
      int unsigned       c;
      int unsigned       idx;
      int unsigned       page;
      int unsigned       count;
      int unsigned       total;
      int unsigned       reserved;
      int unsigned       phase_words;
      int unsigned       random_words;
      logic [ADDR_W-1:0] base;

      reset             <= 1'b1;
      end_of_run        <= 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_ALLOC;
      req_ch.page_count <= '0;
      req_ch.address    <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_REGION_BASE;
      csr_ch.data       <= '0;
      quiet          = 1'b0;
      words_sent     = 0;
      words_returned = 0;
      runs_granted   = 0;
      runs_released  = 0;
      settings_used  = 0;
      cur_base       = REGION_BASE_RST;
      cur_total      = MAX_PAGES_DEF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small map near the top of the address space, one reserved page.
      base = 32'hFFFF_E000;
      configure(base, 8, 1);
      send_word(ACT_ALLOC, 0, $urandom);                   // zero count
      send_word(ACT_ALLOC, 1, $urandom);                   // page 1
      send_word(ACT_ALLOC, 2, $urandom);                   // pages 2-3, address wraps to 0
      send_word(ACT_ALLOC, 8, $urandom);                   // more than is free
      send_word(ACT_ALLOC, 1024, $urandom);
      send_word(ACT_ALLOC, 2047, $urandom);
      send_word(ACT_FREE, 0, 32'hFFFF_F001);               // not page aligned
      send_word(ACT_FREE, 2047, base + (5 << PAGE_SHIFT)); // no run starts there
      send_word(ACT_FREE, 0, base + (9 << PAGE_SHIFT));    // beyond the managed pages
      send_word(ACT_FREE, 0, 32'hFFFF_FFFF);
      send_word(ACT_FREE, 0, 32'h0000_0000);               // the run at page 2
      send_word(ACT_FREE, 0, 32'h0000_0000);               // same address again, now stale
      send_word(ACT_ALLOC, 4, $urandom);                   // pages 2-5

      // Shrink the map under the run at page 2, then free it whole.
      configure(base, 3, 1);
      send_word(ACT_FREE, 0, base + (2 << PAGE_SHIFT));
      // Oversized page count saturates to the full map.
      configure(base, 2047, 0);
      send_word(ACT_ALLOC, 1024, $urandom);
      send_word(ACT_FREE, 0, base + (1 << PAGE_SHIFT));
      send_word(ACT_ALLOC, 1024, $urandom);
      send_word(ACT_FREE, 0, base);

      // Every page reserved, then no pages managed at all.
      configure(base, 1024, 2047);
      send_word(ACT_ALLOC, 1, $urandom);
      configure(base, 0, 0);
      send_word(ACT_ALLOC, 1, $urandom);
      send_word(ACT_FREE, 0, base);

      // Only the last page left outside the reserved area.
      configure(32'h0000_0000, 1024, 1023);
      write_register(CSR_SPARE_INDEX, $urandom);
      send_word(ACT_ALLOC, 1, $urandom);
      send_word(ACT_ALLOC, 1, $urandom);
      send_word(ACT_FREE, 0, 32'h003F_F000);
      wait_until_idle();
      live_pages.delete();

      // Random settings, each with a batch of mostly well-formed traffic.
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         c = $urandom_range(0, 9);
         if (c < 6)       total = $urandom_range(4, 96);
         else if (c == 6) total = 1024;
         else if (c == 7) total = $urandom_range(1025, 2047);
         else if (c == 8) total = $urandom_range(97, 1023);
         else             total = $urandom_range(0, 3);
         c = $urandom_range(0, 9);
         if (c < 6)       reserved = $urandom_range(0, 4);
         else if (c < 8)  reserved = $urandom_range(0, (total > 1024) ? 1024 : total);
         else if (c == 8) reserved = 0;
         else             reserved = $urandom_range(0, 2047);
         c = $urandom_range(0, 7);
         if (c < 6)       base = $urandom & 32'hFFFF_F000;
         else if (c == 6) base = $urandom;
         else             base = 32'hFFFF_F000;
         configure(base, total, reserved);
         quiet       = ($urandom_range(0, 3) == 0);
         phase_words = $urandom_range(30, 70);

         repeat (phase_words) begin
            k = $urandom_range(0, 99);
            if (k < 45 || (k < 85 && live_pages.size() == 0)) begin
               // Mostly small runs; now and then zero, up to the map, or oversized.
               c = $urandom_range(0, 19);
               if (c == 0)      count = 0;
               else if (c == 1) count = $urandom_range(1024, 2047);
               else if (c < 5)  count = $urandom_range(1, cur_total + 1);
               else             count = $urandom_range(1, 8);
               send_word(ACT_ALLOC, count, $urandom);
            end else if (k < 85) begin
               idx  = $urandom_range(0, live_pages.size() - 1);
               page = live_pages[idx];
               live_pages.delete(idx);
               stale_pages.push_back(page);
               if (stale_pages.size() > STALE_DEPTH) void'(stale_pages.pop_front());
               send_word(ACT_FREE, $urandom_range(0, 2047), cur_base + (page << PAGE_SHIFT));
            end else if (k < 90) begin
               page = (stale_pages.size() != 0)
                      ? stale_pages[$urandom_range(0, stale_pages.size() - 1)]
                      : $urandom_range(0, 1023);
               send_word(ACT_FREE, $urandom_range(0, 2047), cur_base + (page << PAGE_SHIFT));
            end else if (k < 95) begin
               send_word(ACT_FREE, $urandom_range(0, 2047),
                         cur_base + ($urandom_range(0, 1023) << PAGE_SHIFT)
                         + $urandom_range(1, 4095));
            end else begin
               send_word(ACT_FREE, $urandom_range(0, 2047), $urandom);
            end
            random_words++;
         end

         // Now and then give back every run still held.
         if ($urandom_range(0, 1) == 0) begin
            while (live_pages.size() != 0) begin
               page = live_pages.pop_front();
               send_word(ACT_FREE, $urandom_range(0, 2047), cur_base + (page << PAGE_SHIFT));
               random_words++;
            end
         end
      end

      // Let any late or stray response word show up before the verdict.
      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("%0d request words over %0d register settings; %0d runs granted, %0d released.",
               words_sent, settings_used, runs_granted, runs_released);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
